// ----- rtl/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// Preprocessor token classifier package
// Kind codes, directive word table and field widths shared by the classifier,
// its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package ptc_pkg;

    // Field widths of the channels.
    localparam int TEXT_BYTES  = 7;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int KIND_W      = 6;

    // Kind codes.
    localparam logic [KIND_W-1:0] K_RAW      = 6'd0;
    localparam logic [KIND_W-1:0] K_WS       = 6'd1;
    localparam logic [KIND_W-1:0] K_CHARLIT  = 6'd2;
    localparam logic [KIND_W-1:0] K_STRLIT   = 6'd3;
    localparam logic [KIND_W-1:0] K_NUMBER   = 6'd4;
    localparam logic [KIND_W-1:0] K_PREPROC  = 6'd5;
    localparam logic [KIND_W-1:0] K_LINECOM  = 6'd6;
    localparam logic [KIND_W-1:0] K_MULTICOM = 6'd7;
    localparam logic [KIND_W-1:0] K_SCOPE    = 6'd8;
    localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd9;
    localparam logic [KIND_W-1:0] K_EQ       = 6'd10;
    localparam logic [KIND_W-1:0] K_NOTEQ    = 6'd11;
    localparam logic [KIND_W-1:0] K_AND      = 6'd12;
    localparam logic [KIND_W-1:0] K_OR       = 6'd13;
    localparam logic [KIND_W-1:0] K_INCR     = 6'd14;
    localparam logic [KIND_W-1:0] K_LSHIFT   = 6'd15;
    localparam logic [KIND_W-1:0] K_LEQ      = 6'd16;
    localparam logic [KIND_W-1:0] K_RSHIFT   = 6'd17;
    localparam logic [KIND_W-1:0] K_GEQ      = 6'd18;
    localparam logic [KIND_W-1:0] K_PTRMEM   = 6'd19;
    localparam logic [KIND_W-1:0] K_ARROW    = 6'd20;
    localparam logic [KIND_W-1:0] K_DECR     = 6'd21;
    localparam logic [KIND_W-1:0] K_ELLIPSIS = 6'd22;
    localparam logic [KIND_W-1:0] K_IDENT    = 6'd23;
    localparam logic [KIND_W-1:0] K_DEFINED  = 6'd36;
    localparam logic [KIND_W-1:0] K_LAST     = K_DEFINED;

    // Directive words. Text is right-justified, so the first character of a
    // word of length n sits at bits [8*n-1 -: 8].
    localparam int NUM_WORDS    = 13;
    localparam int MAX_WORD_LEN = 7;

    localparam logic [8*MAX_WORD_LEN-1:0] WORD_TEXT [NUM_WORDS] = '{
        56'("if"), 56'("elif"), 56'("else"), 56'("line"), 56'("endif"),
        56'("ifdef"), 56'("error"), 56'("undef"), 56'("pragma"),
        56'("ifndef"), 56'("define"), 56'("include"), 56'("defined")
    };

    localparam int WORD_LEN [NUM_WORDS] = '{
        2, 4, 4, 4, 5, 5, 5, 5, 6, 6, 6, 7, 7
    };

    localparam logic [KIND_W-1:0] WORD_KIND [NUM_WORDS] = '{
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31,
        6'd32, 6'd33, 6'd34, 6'd35, K_DEFINED
    };

    // Pipeline depth from input register to output register.
    localparam int PIPE_DEPTH = 3;

endpackage

// ----- rtl/ptc_if.sv -----
// ----------------------------------------------------------------------------
// Classifier channel interfaces
// Valid/ready channels for token words in and class words out.
// ----------------------------------------------------------------------------

// Token word channel: seven text bytes from the token start and its length.
interface ptc_tok_if
    import ptc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte0;
    logic [BYTE_W-1:0] text_byte1;
    logic [BYTE_W-1:0] text_byte2;
    logic [BYTE_W-1:0] text_byte3;
    logic [BYTE_W-1:0] text_byte4;
    logic [BYTE_W-1:0] text_byte5;
    logic [BYTE_W-1:0] text_byte6;
    logic [LEN_W-1:0]  token_length;

    modport source (
        output valid, text_byte0, text_byte1, text_byte2, text_byte3,
               text_byte4, text_byte5, text_byte6, token_length,
        input  ready
    );

    modport sink (
        input  valid, text_byte0, text_byte1, text_byte2, text_byte3,
               text_byte4, text_byte5, text_byte6, token_length,
        output ready
    );
endinterface

// Class word channel: kind code and raw character code.
interface ptc_cls_if
    import ptc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind_class;
    logic [BYTE_W-1:0] char_code;

    modport source (
        output valid, kind_class, char_code,
        input  ready
    );

    modport sink (
        input  valid, kind_class, char_code,
        output ready
    );
endinterface

// ----- rtl/ptc_word_match.sv -----
// ----------------------------------------------------------------------------
// Directive word matcher
// Compares the token's leading bytes and length against every directive word
// in parallel and gives one hit bit per word.
// ----------------------------------------------------------------------------
module ptc_word_match
    import ptc_pkg::*;
(
    input  logic [BYTE_W-1:0]    text [TEXT_BYTES],
    input  logic [LEN_W-1:0]     token_length,
    output logic [NUM_WORDS-1:0] hit
);

    // A word hits when the length is exact and each of its bytes agrees.
    always_comb
    begin
        logic same;
        hit = '0;
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            same = (token_length == LEN_W'(WORD_LEN[w]));
            for (int i = 0; i < MAX_WORD_LEN; i++)
            begin
                if (i < WORD_LEN[w])
                begin
                    same = same &&
                        (text[i] == WORD_TEXT[w][8*(WORD_LEN[w]-1-i) +: 8]);
                end
            end
            hit[w] = same;
        end
    end

endmodule

// ----- rtl/preproc_token_classifier.sv -----
// ----------------------------------------------------------------------------
// Preprocessor token classifier
// Gives the kind class of a token from its first seven bytes and its length.
// ----------------------------------------------------------------------------
// Usage:
// Token words arrive on the tok channel (valid/ready): the seven text bytes
// from the token start, zero past the end of the text, and the length.
// One class word per token leaves on the cls channel: kind_class and, for
// raw characters, char_code.
// The block is a three-stage pipeline: byte and length compares, then the
// first-byte dispatch and operator decode, then the final select into the
// output register. One word is accepted per cycle, sustained, while the
// receiver keeps cls.ready high.
// When the receiver stalls, each stage holds its word and the stages behind
// it keep filling; tok.ready falls only once all three stages are full.
// Reset empties the pipeline; payload registers are not cleared.
// ----------------------------------------------------------------------------
module preproc_token_classifier
    import ptc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ptc_tok_if.sink    tok,
    ptc_cls_if.source  cls
);

    // Result select of the second stage.
    typedef enum logic [1:0] {
        SEL_FIXED,
        SEL_WORD,
        SEL_OP
    } sel_t;

    // Operator decode on the first byte and up to two followers.
    function automatic logic [KIND_W-1:0] op_kind(
        input logic [BYTE_W-1:0] c0,
        input logic [BYTE_W-1:0] c1,
        input logic [BYTE_W-1:0] c2
    );
        logic [KIND_W-1:0] k;
        k = K_RAW;
        unique case (c0)
            ":":
            begin
                if (c1 == ":") k = K_SCOPE;
            end
            "*", "/", "%", "^":
            begin
                if (c1 == "=") k = K_ASSIGN;
            end
            "=":
            begin
                if (c1 == "=") k = K_EQ;
            end
            "!":
            begin
                if (c1 == "=") k = K_NOTEQ;
            end
            "&":
            begin
                priority if (c1 == "&") k = K_AND;
                else if (c1 == "=")     k = K_ASSIGN;
                else                    k = K_RAW;
            end
            "|":
            begin
                priority if (c1 == "|") k = K_OR;
                else if (c1 == "=")     k = K_ASSIGN;
                else                    k = K_RAW;
            end
            "+":
            begin
                priority if (c1 == "+") k = K_INCR;
                else if (c1 == "=")     k = K_ASSIGN;
                else                    k = K_RAW;
            end
            "<":
            begin
                priority if (c1 == "<") k = (c2 == "=") ? K_ASSIGN : K_LSHIFT;
                else if (c1 == "=")     k = K_LEQ;
                else                    k = K_RAW;
            end
            ">":
            begin
                priority if (c1 == ">") k = (c2 == "=") ? K_ASSIGN : K_RSHIFT;
                else if (c1 == "=")     k = K_GEQ;
                else                    k = K_RAW;
            end
            "-":
            begin
                priority if (c1 == ">") k = (c2 == "*") ? K_PTRMEM : K_ARROW;
                else if (c1 == "-")     k = K_DECR;
                else if (c1 == "=")     k = K_ASSIGN;
                else                    k = K_RAW;
            end
            ".":
            begin
                priority if (c1 == "." && c2 == ".") k = K_ELLIPSIS;
                else if (c1 == "*")                  k = K_PTRMEM;
                else                                 k = K_RAW;
            end
            default:
            begin
                k = K_RAW;
            end
        endcase
        return k;
    endfunction

    // Stage valid bits and per-stage ready.
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3      = !v3_reg || cls.ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign tok.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= tok.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    // Stage one: directive word compares; the three dispatch bytes ride along.
    logic [BYTE_W-1:0]    text [TEXT_BYTES];
    logic [NUM_WORDS-1:0] hit_next;
    logic [NUM_WORDS-1:0] hit_reg;
    logic [BYTE_W-1:0]    c0_reg, c1_reg, c2_reg;

    assign text[0] = tok.text_byte0;
    assign text[1] = tok.text_byte1;
    assign text[2] = tok.text_byte2;
    assign text[3] = tok.text_byte3;
    assign text[4] = tok.text_byte4;
    assign text[5] = tok.text_byte5;
    assign text[6] = tok.text_byte6;

    ptc_word_match u_word_match (
        .text         (text),
        .token_length (tok.token_length),
        .hit          (hit_next)
    );

    always_ff @(posedge clk)
    begin
        if (rdy1 && tok.valid)
        begin
            hit_reg <= hit_next;
            c0_reg  <= tok.text_byte0;
            c1_reg  <= tok.text_byte1;
            c2_reg  <= tok.text_byte2;
        end
    end

    // Stage two: first-byte dispatch, operator decode and word kind.
    sel_t              sel_next, sel_reg;
    logic [KIND_W-1:0] fixed_kind_next, fixed_kind_reg;
    logic              lf_next, lf_reg;
    logic [KIND_W-1:0] word_kind_next, word_kind_reg;
    logic [KIND_W-1:0] op_kind_next, op_kind_reg;
    logic [BYTE_W-1:0] c0_s2_reg;
    logic              is_letter, is_digit, is_ws;

    assign is_letter = (c0_reg >= "a" && c0_reg <= "z") ||
                       (c0_reg >= "A" && c0_reg <= "Z") || (c0_reg == "_");
    assign is_digit  = (c0_reg >= "0" && c0_reg <= "9");
    assign is_ws     = (c0_reg == " ") || (c0_reg == 8'h09) ||
                       (c0_reg == 8'h0B) || (c0_reg == 8'h0C);

    always_comb
    begin
        sel_next        = SEL_FIXED;
        fixed_kind_next = K_RAW;
        lf_next         = 1'b0;
        priority if (c0_reg == 8'h0D || c0_reg == 8'h0A)
        begin
            lf_next = 1'b1;
        end
        else if (c0_reg == "'")
        begin
            fixed_kind_next = K_CHARLIT;
        end
        else if (c0_reg == "\"")
        begin
            fixed_kind_next = K_STRLIT;
        end
        else if (c0_reg == "#")
        begin
            fixed_kind_next = K_PREPROC;
        end
        else if (c0_reg == "/" && c1_reg == "/")
        begin
            fixed_kind_next = K_LINECOM;
        end
        else if (c0_reg == "/" && c1_reg == "*")
        begin
            fixed_kind_next = K_MULTICOM;
        end
        else if (is_ws)
        begin
            fixed_kind_next = K_WS;
        end
        else if (is_letter)
        begin
            sel_next = SEL_WORD;
        end
        else if (is_digit)
        begin
            fixed_kind_next = K_NUMBER;
        end
        else
        begin
            sel_next = SEL_OP;
        end
    end

    // At most one word can hit, since words of equal length differ.
    always_comb
    begin
        word_kind_next = K_IDENT;
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            if (hit_reg[w]) word_kind_next = WORD_KIND[w];
        end
    end

    assign op_kind_next = op_kind(c0_reg, c1_reg, c2_reg);

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            sel_reg        <= sel_next;
            fixed_kind_reg <= fixed_kind_next;
            lf_reg         <= lf_next;
            word_kind_reg  <= word_kind_next;
            op_kind_reg    <= op_kind_next;
            c0_s2_reg      <= c0_reg;
        end
    end

    // Stage three: final select into the output register.
    logic [KIND_W-1:0] kind_next, kind_reg;
    logic [BYTE_W-1:0] code_next, code_reg;

    always_comb
    begin
        kind_next = K_RAW;
        code_next = '0;
        unique case (sel_reg)
            SEL_FIXED:
            begin
                kind_next = fixed_kind_reg;
                code_next = lf_reg ? 8'h0A : 8'h00;
            end
            SEL_WORD:
            begin
                kind_next = word_kind_reg;
            end
            SEL_OP:
            begin
                kind_next = op_kind_reg;
                code_next = (op_kind_reg == K_RAW) ? c0_s2_reg : 8'h00;
            end
            default:
            begin
                kind_next = K_RAW;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            kind_reg <= kind_next;
            code_reg <= code_next;
        end
    end

    assign cls.valid      = v3_reg;
    assign cls.kind_class = kind_reg;
    assign cls.char_code  = code_reg;

endmodule

// ----- rtl/ptc_checker.sv -----
// ----------------------------------------------------------------------------
// Classifier port checker
// Watches the classifier's channels for held words, legal class words and
// the bound on words in flight.
// ----------------------------------------------------------------------------
module ptc_checker
    import ptc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              tok_valid,
    input logic              tok_ready,
    input logic              cls_valid,
    input logic              cls_ready,
    input logic [KIND_W-1:0] kind_class,
    input logic [BYTE_W-1:0] char_code
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

    // Words accepted but not yet delivered.
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             tok_acc, cls_acc;

    assign tok_acc = tok_valid && tok_ready;
    assign cls_acc = cls_valid && cls_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (tok_acc && !cls_acc) cnt_next = cnt_reg + 1'b1;
        if (!tok_acc && cls_acc) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cnt_reg <= '0;
        else        cnt_reg <= cnt_next;
    end

    // A stalled class word stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cls_valid && !cls_ready |=>
            cls_valid && $stable(kind_class) && $stable(char_code))
        else $error("class word changed while stalled");

    // Kind codes stay within the defined range.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cls_valid |-> kind_class <= K_LAST)
        else $error("kind code out of range");

    // A character code comes only with a raw character.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        cls_valid && char_code != '0 |-> kind_class == K_RAW)
        else $error("character code on a non-raw class");

    // No word appears from nowhere and no more than the pipeline holds.
    a_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(PIPE_DEPTH) && (!cls_valid || cnt_reg != '0))
        else $error("words in flight out of bounds");

endmodule

bind preproc_token_classifier ptc_checker u_ptc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (tok.valid),
    .tok_ready  (tok.ready),
    .cls_valid  (cls.valid),
    .cls_ready  (cls.ready),
    .kind_class (cls.kind_class),
    .char_code  (cls.char_code)
);
